[hdl/fpps_pkg.sv]
// Shared types and constants for the farthest point pair search block.
// Used by fpps_ctrl, fpps_datapath and farthest_point_pair_search; no dependencies.
`default_nettype none

package fpps_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int COORD_BITS_DEF = 8;

  // fixed widths of the channel fields
  localparam int IN_COORD_W = 8;
  localparam int IDX_OUT_W  = 6;
  localparam int DIST_OUT_W = 17;

  typedef struct packed {
    logic [IN_COORD_W-1:0] point_x;
    logic [IN_COORD_W-1:0] point_y;
    logic                  last_point;
  } in_item_t;

  typedef struct packed {
    logic [IDX_OUT_W-1:0]  first_index;
    logic [IDX_OUT_W-1:0]  second_index;
    logic [DIST_OUT_W-1:0] distance_sq;
    logic                  pair_found;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_WALK,
    ST_DRAIN,
    ST_FINISH
  } fpps_state_e;

  // controller -> datapath
  typedef struct packed {
    logic store;    // write the input beat into the point store
    logic start;    // reset the pair walk and the kept pair
    logic issue;    // read the current pair and step to the next one
    logic publish;  // load the result register, empty the store
  } fpps_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic enough;     // at least two points once the current beat is stored
    logic last_pair;  // walk sits on the final pair
    logic pipe_busy;  // a pair is still in flight
    logic out_free;   // result register can take a new result
  } fpps_stat_t;

endpackage

`default_nettype wire

[hdl/fpps_ctrl.sv]
// Sequencer for the farthest pair search: load, pair walk, drain, result.
// Depends on fpps_pkg.
`default_nettype none

module fpps_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 in_last_i,
  output logic                in_ready_o,
  input  fpps_pkg::fpps_stat_t stat_i,
  output fpps_pkg::fpps_cmd_t  cmd_o
);
  import fpps_pkg::*;

  fpps_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: begin
        if (in_valid_i && in_last_i) begin
          state_d = stat_i.enough ? ST_WALK : ST_FINISH;
        end
      end
      ST_WALK: begin
        if (stat_i.last_pair) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat_i.pipe_busy) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat_i.out_free) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    unique case (state_q)
      ST_LOAD: begin
        in_ready_o  = 1'b1;
        cmd_o.store = in_valid_i;
        cmd_o.start = in_valid_i && in_last_i;
      end
      ST_WALK: begin
        cmd_o.issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_FINISH: begin
        cmd_o.publish = stat_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/fpps_datapath.sv]
// Point store, pair index walk, distance pipeline, kept pair and result register.
// Depends on fpps_pkg.
`default_nettype none

module fpps_datapath #(
  parameter int MAX_POINTS = fpps_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = fpps_pkg::COORD_BITS_DEF
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  fpps_pkg::in_item_t    in_item_i,
  input  fpps_pkg::fpps_cmd_t   cmd_i,
  output fpps_pkg::fpps_stat_t  stat_o,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output fpps_pkg::out_item_t   out_item_o
);
  import fpps_pkg::*;

  localparam int IDX_W  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int PT_W   = 2 * COORD_BITS;
  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int DIST_W = SQ_W + 1;

  // ---------------- point store ----------------
  logic [PT_W-1:0]       pt_mem_q [MAX_POINTS];
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  not_full;
  logic [COORD_BITS-1:0] wr_x, wr_y;

  assign not_full = (count_q < CNT_W'(MAX_POINTS));
  assign wr_x     = COORD_BITS'(in_item_i.point_x);
  assign wr_y     = COORD_BITS'(in_item_i.point_y);

  always_ff @(posedge clk_i) begin
    if (cmd_i.store && not_full) begin
      pt_mem_q[count_q[IDX_W-1:0]] <= {wr_x, wr_y};
    end
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.publish) begin
      count_d = '0;
    end else if (cmd_i.store && not_full) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // ---------------- pair walk ----------------
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d;
  logic             row_end;
  logic [CNT_W-1:0] i_ext, j_ext;

  assign i_ext   = CNT_W'(i_q);
  assign j_ext   = CNT_W'(j_q);
  assign row_end = (j_ext + CNT_W'(1) == count_q);

  always_comb begin
    i_d = i_q;
    j_d = j_q;
    if (cmd_i.start) begin
      i_d = '0;
      j_d = IDX_W'(1);
    end else if (cmd_i.issue) begin
      if (row_end) begin
        i_d = IDX_W'(i_ext + CNT_W'(1));
        j_d = IDX_W'(i_ext + CNT_W'(2));
      end else begin
        j_d = IDX_W'(j_ext + CNT_W'(1));
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else begin
      i_q <= i_d;
      j_q <= j_d;
    end
  end

  // ---------------- stage 1: registered reads ----------------
  logic             v1_q;
  logic [PT_W-1:0]  rd_a_q, rd_b_q;
  logic [IDX_W-1:0] i1_q, j1_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_a_q <= pt_mem_q[i_q];
      rd_b_q <= pt_mem_q[j_q];
      i1_q   <= i_q;
      j1_q   <= j_q;
    end
  end

  // ---------------- stage 2: squared differences ----------------
  logic                  v2_q;
  logic [COORD_BITS-1:0] ax, ay, bx, by, dx, dy;
  logic [SQ_W-1:0]       sqx_d, sqy_d, sqx_q, sqy_q;
  logic [IDX_W-1:0]      i2_q, j2_q;

  assign {ax, ay} = rd_a_q;
  assign {bx, by} = rd_b_q;
  assign dx       = (ax >= bx) ? (ax - bx) : (bx - ax);
  assign dy       = (ay >= by) ? (ay - by) : (by - ay);
  assign sqx_d    = SQ_W'(dx) * SQ_W'(dx);
  assign sqy_d    = SQ_W'(dy) * SQ_W'(dy);

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      i2_q  <= i1_q;
      j2_q  <= j1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
    end
  end

  // ---------------- stage 3: sum and keep the farthest ----------------
  logic [DIST_W-1:0] pair_dist;
  logic [DIST_W-1:0] best_dist_q;
  logic [IDX_W-1:0]  best_i_q, best_j_q;
  logic              have_best_q;
  logic              take;

  assign pair_dist = DIST_W'(sqx_q) + DIST_W'(sqy_q);
  // strict compare: on ties the earlier pair stays
  assign take = v2_q && (!have_best_q || (pair_dist > best_dist_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_dist_q <= pair_dist;
      best_i_q    <= i2_q;
      best_j_q    <= j2_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
    end else if (cmd_i.start) begin
      have_best_q <= 1'b0;
    end else if (take) begin
      have_best_q <= 1'b1;
    end
  end

  // ---------------- result register ----------------
  logic      out_valid_q;
  out_item_t out_item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      if (have_best_q) begin
        out_item_q.first_index  <= IDX_OUT_W'(best_i_q);
        out_item_q.second_index <= IDX_OUT_W'(best_j_q);
        out_item_q.distance_sq  <= DIST_OUT_W'(best_dist_q);
        out_item_q.pair_found   <= 1'b1;
      end else begin
        out_item_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.publish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // a stored point count of one already means two after this beat
  assign stat_o.enough    = (count_q != '0);
  assign stat_o.last_pair = row_end && (i_ext + CNT_W'(2) == count_q);
  assign stat_o.pipe_busy = v1_q || v2_q;
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

endmodule

`default_nettype wire

[hdl/farthest_point_pair_search.sv]
// Farthest point pair search: points are loaded one per input beat until a beat with
// last_point set. The block then walks every pair (i, j), i < j, one pair per cycle
// through the two read ports of the point memory; after the walk the distance pipeline
// drains and the result is handed off before the next set can load. Only the first
// MAX_POINTS points of a set are kept. The result carries the pair of largest squared
// distance (earliest pair on ties), or pair_found = 0 with all other fields zero when
// fewer than two points were held.
// Depends on fpps_pkg, fpps_ctrl and fpps_datapath.
`default_nettype none

module farthest_point_pair_search #(
  parameter int MAX_POINTS = fpps_pkg::MAX_POINTS_DEF,
  parameter int COORD_BITS = fpps_pkg::COORD_BITS_DEF
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  fpps_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  output fpps_pkg::out_item_t out_item_o
);
  import fpps_pkg::*;

  fpps_cmd_t  cmd;
  fpps_stat_t stat;

  fpps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last_point),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fpps_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // loading only happens with the distance pipeline empty
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !stat.pipe_busy)
    else $error("input accepted while pairs in flight");

  // a last beat starts the search, so loading stops
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_item_i.last_point) |=> !in_ready_o)
    else $error("ready after last beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.pair_found) |->
      (out_item_o.distance_sq == '0 && out_item_o.first_index == '0 &&
       out_item_o.second_index == '0))
    else $error("empty result with nonzero fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.pair_found && (MAX_POINTS <= 64)) |->
      (out_item_o.second_index > out_item_o.first_index))
    else $error("pair indices out of order");

endmodule

`default_nettype wire
